### design/integer_square_root_top_defines.svh
// assertion macros for the square root controller
`ifndef INTEGER_SQUARE_ROOT_TOP_DEFINES_SVH
`define INTEGER_SQUARE_ROOT_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked on every clock edge outside reset
`define ISR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// checked on every clock edge, reset included
`define ISR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ISR_ASSERT(lbl, prop, msg)
`define ISR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### design/isr_pkg.sv
// shared types and constants of the integer square root block
package isr_pkg;

  // default operand width
  localparam int unsigned DataWidthDef = 32;

  // controller states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_CALC
  } isr_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // take a new operand
    logic step;   // settle one root bit
    logic store;  // write the finished root to the output register
  } isr_cmd_t;

endpackage

### design/integer_square_root_top.sv
// shift-subtract datapath: one root bit per cycle, but the last bit waits while the output register is full
// the next operand is taken on the last root bit
// the output register lets a finished root wait while the next operand is worked on
// reset: synchronous, clears the controller state and the output valid; no clearing pass
module integer_square_root_top #(
  parameter int unsigned DATA_WIDTH = isr_pkg::DataWidthDef
) (
  input  logic clk,
  input  logic rst,
  // slave side, tdata: operand [DATA_WIDTH-1:0], zero padded to bytes
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  // master side, tdata: root [DATA_WIDTH/2:0], zero padded to bytes
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((DATA_WIDTH/2+1+7)/8)*8-1:0]   m_axis_tdata
);
  import isr_pkg::*;

  localparam int unsigned OutW = ((DATA_WIDTH / 2 + 1 + 7) / 8) * 8;

  isr_cmd_t              cmd;
  logic [DATA_WIDTH/2:0] root;

  // sequencing and handshakes
  isr_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .cmd      (cmd)
  );

  // root arithmetic
  isr_dp #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .operand(s_axis_tdata[DATA_WIDTH-1:0]),
    .root   (root)
  );

  // pad the root word to whole bytes
  assign m_axis_tdata = OutW'(root);

endmodule

### design/isr_ctrl.sv
// controller: sequences the root bits and runs both stream handshakes
`include "integer_square_root_top_defines.svh"

module isr_ctrl #(
  parameter int unsigned DATA_WIDTH = isr_pkg::DataWidthDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output isr_pkg::isr_cmd_t cmd
);
  import isr_pkg::*;

  localparam int unsigned NSteps = DATA_WIDTH / 2;
  localparam int unsigned CntW   = $clog2(NSteps);

  isr_state_t      state, state_next;
  logic [CntW-1:0] count, count_next;
  logic            out_valid_next;
  logic            last;
  logic            slot_free;

  // state, bit counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    last       = (state == ST_CALC) && (count == CntW'(NSteps - 1));
    slot_free  = !out_valid || out_ready;
    cmd.store  = last && slot_free;
    cmd.step   = (state == ST_CALC) && (!last || slot_free);
    in_ready   = (state == ST_IDLE) || cmd.store;
    cmd.load   = in_valid && in_ready;
    state_next = state;
    count_next = count;

    unique case (state)
      ST_IDLE: begin
        if (cmd.load) begin
          state_next = ST_CALC;
          count_next = '0;
        end
      end
      ST_CALC: begin
        if (cmd.load) begin
          count_next = '0;
        end else if (cmd.store) begin
          state_next = ST_IDLE;
        end else if (cmd.step) begin
          count_next = count + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // output word held until taken
    if (cmd.store) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  `ISR_ASSERT(a_load_mid_calc, (cmd.load && state == ST_CALC) |-> cmd.store, "word taken while root busy")
  `ISR_ASSERT(a_store_sets_valid, cmd.store |=> out_valid, "stored root not presented")
  `ISR_ASSERT(a_count_range, (state == ST_CALC) |-> (count <= CntW'(NSteps - 1)), "bit counter past last bit")
  `ISR_ASSERT(a_no_step_idle, (state == ST_IDLE) |-> (!cmd.step && !cmd.store), "datapath worked while idle")
  `ISR_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == ST_IDLE && !out_valid), "reset left controller busy")

endmodule

### design/isr_dp.sv
// datapath: shift-subtract square root, one root bit per step, plus output register
module isr_dp #(
  parameter int unsigned DATA_WIDTH = isr_pkg::DataWidthDef
) (
  input  logic                    clk,
  input  isr_pkg::isr_cmd_t       cmd,
  input  logic [DATA_WIDTH-1:0]   operand,
  output logic [DATA_WIDTH/2:0]   root
);
  import isr_pkg::*;

  localparam int unsigned NSteps = DATA_WIDTH / 2;
  localparam int unsigned OpW    = 2 * NSteps;
  localparam int unsigned RemW   = NSteps + 2;

  logic [OpW-1:0]    opnd;
  logic [RemW-1:0]   rem;
  logic [NSteps-1:0] part;
  logic              neg;
  logic [RemW-1:0]   rem_sh;
  logic [RemW-1:0]   trial;
  logic              take;
  logic [RemW-1:0]   rem_next;
  logic [NSteps-1:0] part_next;

  // one root bit: bring down two operand bits, try to subtract 4*root+1
  always_comb begin
    rem_sh    = {rem[NSteps-1:0], opnd[OpW-1 -: 2]};
    trial     = {part, 2'b01};
    take      = (rem_sh >= trial);
    rem_next  = take ? (rem_sh - trial) : rem_sh;
    part_next = {part[NSteps-2:0], take};
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opnd <= operand[OpW-1:0];
      neg  <= operand[DATA_WIDTH-1];
      rem  <= '0;
      part <= '0;
    end else if (cmd.step) begin
      opnd <= {opnd[OpW-3:0], 2'b00};
      rem  <= rem_next;
      part <= part_next;
    end
  end

  // output register, all ones for a negative operand
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      root <= neg ? '1 : {1'b0, part_next};
    end
  end

endmodule
